### sv/tolpf_pkg.sv
package tolpf_pkg;

    localparam int AXES        = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 32;
    localparam int NUM_COEFS   = 7;
    localparam int CFG_INDEX_BITS = 3;

    localparam int COEF_FRAC_BITS_DEFAULT  = 28;
    localparam int STATE_FRAC_BITS_DEFAULT = 12;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam cfg_index_t REG_FF0 = 3'd0;
    localparam cfg_index_t REG_FF1 = 3'd1;
    localparam cfg_index_t REG_FF2 = 3'd2;
    localparam cfg_index_t REG_FF3 = 3'd3;
    localparam cfg_index_t REG_FB1 = 3'd4;
    localparam cfg_index_t REG_FB2 = 3'd5;
    localparam cfg_index_t REG_FB3 = 3'd6;

    localparam coef_t COEF_RESET [NUM_COEFS] = '{
        32'sd777978,
        32'sd2333935,
        32'sd2333935,
        32'sd777978,
        -32'sd637291205,
        32'sd517907468,
        -32'sd142827894
    };

endpackage

### sv/third_order_lowpass_three_axis_core.sv
// Third-order direct-form-I low-pass filter applied to three accelerometer axes with one shared
// set of Q4.28 coefficients (ff0..ff3, fb1..fb3), written through the configuration port; the
// user must write them only while the block is idle, as the block itself does not enforce this.
// Each transfer on the input channel carries one signed sample per axis and yields exactly one
// transfer on the result channel with the filtered value per axis, rounded and saturated to
// sixteen bits; the kept outputs hold twelve fraction bits and saturate to 32 bits. The block
// takes one transfer per clock cycle while the result channel is not stalled; the multipliers
// and adder tree sit between the input register and the result register, whose load also
// updates the per-axis history that the next sample's feedback products read. Reset clears
// the history and restores the default coefficients.
module third_order_lowpass_three_axis_core #(
    parameter int COEF_FRAC_BITS  = tolpf_pkg::COEF_FRAC_BITS_DEFAULT,
    parameter int STATE_FRAC_BITS = tolpf_pkg::STATE_FRAC_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  tolpf_pkg::cfg_index_t          cfg_index,
    input  tolpf_pkg::coef_t               cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tolpf_pkg::sample_t             s_sample_x,
    input  tolpf_pkg::sample_t             s_sample_y,
    input  tolpf_pkg::sample_t             s_sample_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tolpf_pkg::sample_t             m_filtered_x,
    output tolpf_pkg::sample_t             m_filtered_y,
    output tolpf_pkg::sample_t             m_filtered_z
);
    import tolpf_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int PFF_W = SB + COEF_BITS;
    localparam int FF_W  = PFF_W + 2;
    localparam int PFB_W = 2 * COEF_BITS;
    localparam int ACC_W = ((FF_W + STATE_FRAC_BITS) > PFB_W ?
                            (FF_W + STATE_FRAC_BITS) : PFB_W) + 3;
    localparam int QW    = ACC_W - COEF_FRAC_BITS;
    localparam int RW    = COEF_BITS + 2;

    localparam logic signed [ACC_W-1:0] ROUND_ACC =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [RW-1:0] ROUND_OUT = RW'((2 ** STATE_FRAC_BITS) / 2);

    coef_t   coef_reg [NUM_COEFS];
    sample_t in_reg   [AXES];
    logic    in_valid_reg;
    logic    out_valid_reg;
    sample_t out_reg  [AXES];
    sample_t xh_reg   [AXES][3];
    coef_t   yh_reg   [AXES][3];

    logic signed [PFF_W-1:0] pff  [AXES][4];
    logic signed [PFB_W-1:0] pfb  [AXES][3];
    logic signed [FF_W-1:0]  ffsum [AXES];
    logic signed [ACC_W-1:0] acc  [AXES];
    logic signed [QW-1:0]    q    [AXES];
    coef_t                   y_next [AXES];
    logic signed [RW-1:0]    r    [AXES];
    sample_t                 filt_next [AXES];

    logic in_load;
    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_load  = s_valid && s_ready;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            pff[a][0] = PFF_W'(coef_reg[REG_FF0]) * PFF_W'(in_reg[a]);
            pff[a][1] = PFF_W'(coef_reg[REG_FF1]) * PFF_W'(xh_reg[a][0]);
            pff[a][2] = PFF_W'(coef_reg[REG_FF2]) * PFF_W'(xh_reg[a][1]);
            pff[a][3] = PFF_W'(coef_reg[REG_FF3]) * PFF_W'(xh_reg[a][2]);
            pfb[a][0] = PFB_W'(coef_reg[REG_FB1]) * PFB_W'(yh_reg[a][0]);
            pfb[a][1] = PFB_W'(coef_reg[REG_FB2]) * PFB_W'(yh_reg[a][1]);
            pfb[a][2] = PFB_W'(coef_reg[REG_FB3]) * PFB_W'(yh_reg[a][2]);

            ffsum[a] = FF_W'(pff[a][0]) + FF_W'(pff[a][1])
                     + FF_W'(pff[a][2]) + FF_W'(pff[a][3]);
            acc[a] = (ACC_W'(ffsum[a]) <<< STATE_FRAC_BITS)
                   - ACC_W'(pfb[a][0]) - ACC_W'(pfb[a][1]) - ACC_W'(pfb[a][2])
                   + ROUND_ACC;
            q[a] = acc[a][ACC_W-1:COEF_FRAC_BITS];

            if (q[a][QW-1:COEF_BITS-1] == '0 || q[a][QW-1:COEF_BITS-1] == '1) begin
                y_next[a] = q[a][COEF_BITS-1:0];
            end else if (q[a][QW-1]) begin
                y_next[a] = {1'b1, {(COEF_BITS-1){1'b0}}};
            end else begin
                y_next[a] = {1'b0, {(COEF_BITS-1){1'b1}}};
            end

            r[a] = (RW'(y_next[a]) + ROUND_OUT) >>> STATE_FRAC_BITS;
            if (r[a][RW-1:SB-1] == '0 || r[a][RW-1:SB-1] == '1) begin
                filt_next[a] = r[a][SB-1:0];
            end else if (r[a][RW-1]) begin
                filt_next[a] = {1'b1, {(SB-1){1'b0}}};
            end else begin
                filt_next[a] = {1'b0, {(SB-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                coef_reg[i] <= COEF_RESET[i];
            end
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_FF0, REG_FF1, REG_FF2, REG_FF3,
                REG_FB1, REG_FB2, REG_FB3: begin
                    coef_reg[cfg_index] <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                for (int k = 0; k < 3; k++) begin
                    xh_reg[a][k] <= '0;
                    yh_reg[a][k] <= '0;
                end
            end
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                for (int a = 0; a < AXES; a++) begin
                    xh_reg[a][0] <= in_reg[a];
                    xh_reg[a][1] <= xh_reg[a][0];
                    xh_reg[a][2] <= xh_reg[a][1];
                    yh_reg[a][0] <= y_next[a];
                    yh_reg[a][1] <= yh_reg[a][0];
                    yh_reg[a][2] <= yh_reg[a][1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_reg[0] <= s_sample_x;
            in_reg[1] <= s_sample_y;
            in_reg[2] <= s_sample_z;
        end
        if (advance) begin
            out_reg <= filt_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_filtered_x = out_reg[0];
    assign m_filtered_y = out_reg[1];
    assign m_filtered_z = out_reg[2];

endmodule

### sv/tolpf_checker.sv
module tolpf_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input tolpf_pkg::sample_t    m_filtered_x,
    input tolpf_pkg::sample_t    m_filtered_y,
    input tolpf_pkg::sample_t    m_filtered_z
);

    // A stalled result keeps its values until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered_x)
            && $stable(m_filtered_y) && $stable(m_filtered_z))
        else $error("stalled result changed");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A new result only ever follows an earlier input transfer that passed through the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input transfer");

    // With the result register empty the input side is always open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while output empty");

endmodule

bind third_order_lowpass_three_axis_core tolpf_checker u_tolpf_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tolpf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 6;
    localparam int CFB          = COEF_FRAC_BITS_DEFAULT;
    localparam int SFB          = STATE_FRAC_BITS_DEFAULT;

    localparam cfg_index_t REG_NONE = 3'd7;
    localparam coef_t COEF_MAX  = 32'sh7fff_ffff;
    localparam coef_t COEF_MIN  = 32'sh8000_0000;
    localparam coef_t COEF_HALF = 32'sd134217728;
    localparam coef_t COEF_TINY = 32'sd32768;
    localparam sample_t SAMPLE_MAX = 16'sh7fff;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    typedef logic signed [79:0] acc_t;

    typedef struct packed {
        sample_t x;
        sample_t y;
        sample_t z;
    } axes_t;

    typedef enum {COEFS_DEFAULT, COEFS_GENTLE, COEFS_WILD, COEFS_EDGE} coef_mix_t;

    class filtered_scoreboard;
        coef_t   coef [NUM_COEFS];
        sample_t x_hist [AXES][3];
        int      y_hist [AXES][3];
        axes_t   filtered_due [$];
        int      errors;

        function new();
            foreach (coef[i]) coef[i] = COEF_RESET[i];
            foreach (x_hist[a, k]) begin
                x_hist[a][k] = '0;
                y_hist[a][k] = 0;
            end
            errors = 0;
        endfunction

        function void write_coef(cfg_index_t idx, coef_t value);
            if (int'(idx) < NUM_COEFS) begin
                coef[idx] = value;
            end
        endfunction

        function sample_t filter_axis(int a, sample_t x);
            acc_t    taps;
            longint  kept;
            longint  rounded;
            taps = acc_t'(coef[REG_FF0]) * acc_t'(x)
                 + acc_t'(coef[REG_FF1]) * acc_t'(x_hist[a][0])
                 + acc_t'(coef[REG_FF2]) * acc_t'(x_hist[a][1])
                 + acc_t'(coef[REG_FF3]) * acc_t'(x_hist[a][2]);
            taps = taps <<< SFB;
            taps = taps - acc_t'(coef[REG_FB1]) * acc_t'(y_hist[a][0])
                        - acc_t'(coef[REG_FB2]) * acc_t'(y_hist[a][1])
                        - acc_t'(coef[REG_FB3]) * acc_t'(y_hist[a][2]);
            taps = taps + (acc_t'(1) <<< (CFB - 1));
            kept = longint'(taps >>> CFB);
            if (kept > 64'sd2147483647) begin
                kept = 64'sd2147483647;
            end else if (kept < -64'sd2147483648) begin
                kept = -64'sd2147483648;
            end
            x_hist[a][2] = x_hist[a][1];
            x_hist[a][1] = x_hist[a][0];
            x_hist[a][0] = x;
            y_hist[a][2] = y_hist[a][1];
            y_hist[a][1] = y_hist[a][0];
            y_hist[a][0] = int'(kept);
            rounded = (kept + (64'sd1 <<< (SFB - 1))) >>> SFB;
            if (rounded > 64'sd32767) begin
                rounded = 64'sd32767;
            end else if (rounded < -64'sd32768) begin
                rounded = -64'sd32768;
            end
            return sample_t'(rounded);
        endfunction

        function void note_sample(axes_t s);
            axes_t want;
            want.x = filter_axis(0, s.x);
            want.y = filter_axis(1, s.y);
            want.z = filter_axis(2, s.z);
            filtered_due.push_back(want);
        endfunction

        function void compare_field(string name, sample_t want, sample_t got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_filtered(axes_t got);
            axes_t want;
            if (filtered_due.size() == 0) begin
                $error("unexpected result: x %0d, y %0d, z %0d", got.x, got.y, got.z);
                errors++;
                return;
            end
            want = filtered_due.pop_front();
            compare_field("filtered_x", want.x, got.x);
            compare_field("filtered_y", want.y, got.y);
            compare_field("filtered_z", want.z, got.z);
        endfunction
    endclass

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       cfg_wen    = 1'b0;
    cfg_index_t cfg_index  = REG_FF0;
    coef_t      cfg_wdata  = '0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    sample_t    s_sample_x = '0;
    sample_t    s_sample_y = '0;
    sample_t    s_sample_z = '0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    sample_t    m_filtered_x;
    sample_t    m_filtered_y;
    sample_t    m_filtered_z;

    bit         no_idle    = 1'b0;
    int         cycle_count = 0;
    coef_t      plan [NUM_COEFS];

    filtered_scoreboard sb = new();

    third_order_lowpass_three_axis_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_x   (s_sample_x),
        .s_sample_y   (s_sample_y),
        .s_sample_z   (s_sample_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered_x (m_filtered_x),
        .m_filtered_y (m_filtered_y),
        .m_filtered_z (m_filtered_z)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_sample(axes_t'{s_sample_x, s_sample_y, s_sample_z});
            end
            if (m_valid && m_ready) begin
                sb.check_filtered(axes_t'{m_filtered_x, m_filtered_y, m_filtered_z});
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= 13);
    end

    task automatic send_sample(axes_t s);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_sample_x <= s.x;
        s_sample_y <= s.y;
        s_sample_z <= s.z;
        do @(posedge aclk); while (!s_ready);
    endtask

    // The sender holds back until every outstanding transfer has been checked.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.filtered_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_index_t idx, coef_t value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        sb.write_coef(idx, value);
    endtask

    task automatic load_coefs(input coef_t values [NUM_COEFS]);
        for (int i = 0; i < NUM_COEFS; i++) begin
            cfg_write(cfg_index_t'(i), values[i]);
        end
        cfg_write(REG_NONE, coef_t'($urandom));
    endtask

    function automatic coef_t pick_coef(coef_mix_t mix, int idx);
        case (mix)
            COEFS_DEFAULT: begin
                return COEF_RESET[idx];
            end
            COEFS_GENTLE: begin
                if (idx < int'(REG_FB1)) begin
                    return coef_t'($urandom_range(0, 1 << 23)) - coef_t'(1 << 22);
                end
                return coef_t'($urandom_range(0, 1 << 27)) - coef_t'(1 << 26);
            end
            COEFS_WILD: begin
                return coef_t'($urandom);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: return COEF_MIN;
                    1: return COEF_MAX;
                    2: return '0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic sample_t pick_sample(sample_t prev);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return sample_t'($urandom);
        end else if (r < 75) begin
            return sample_t'(int'($urandom_range(0, 510)) - 255);
        end else if (r < 85) begin
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end
        return prev;
    endfunction

    initial begin
        coef_mix_t mix_plan [NUM_PHASES];
        axes_t     s;
        mix_plan = '{COEFS_DEFAULT, COEFS_GENTLE, COEFS_WILD,
                     COEFS_EDGE, COEFS_DEFAULT, COEFS_GENTLE};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Default coefficients straight out of reset.
        send_sample('0);
        send_sample('{SAMPLE_MAX, SAMPLE_MIN, 16'sd0});
        send_sample('{SAMPLE_MAX, SAMPLE_MIN, 16'sd0});
        send_sample('{SAMPLE_MAX, SAMPLE_MIN, 16'sd0});
        send_sample('{SAMPLE_MIN, SAMPLE_MAX, 16'sd1});
        send_sample('{SAMPLE_MIN, SAMPLE_MAX, -16'sd1});
        send_sample('{SAMPLE_MAX, SAMPLE_MIN, -16'sd1});
        send_sample('{16'sd1, -16'sd1, 16'sd21845});
        drain();

        // Extreme coefficients drive both the kept and the emitted value into saturation.
        foreach (plan[i]) plan[i] = (i < int'(REG_FB1)) ? COEF_MAX : COEF_MIN;
        load_coefs(plan);
        send_sample('{SAMPLE_MAX, SAMPLE_MIN, 16'sd1});
        send_sample('{SAMPLE_MAX, SAMPLE_MIN, -16'sd1});
        send_sample('{SAMPLE_MIN, SAMPLE_MAX, 16'sd0});
        send_sample('0);
        drain();
        foreach (plan[i]) plan[i] = COEF_MIN;
        load_coefs(plan);
        send_sample('{SAMPLE_MAX, SAMPLE_MIN, 16'sd1});
        send_sample('{SAMPLE_MIN, SAMPLE_MAX, -16'sd1});
        send_sample('0);
        drain();

        // A gain of one half puts the emitted rounding exactly on ties.
        foreach (plan[i]) plan[i] = '0;
        plan[REG_FF0] = COEF_HALF;
        load_coefs(plan);
        send_sample('{16'sd1, -16'sd1, 16'sd3});
        send_sample('{-16'sd3, 16'sd5, -16'sd5});
        send_sample('{SAMPLE_MAX, SAMPLE_MIN, 16'sd0});
        drain();

        // A tiny gain puts the rounding of the kept value exactly on ties.
        plan[REG_FF0] = COEF_TINY;
        load_coefs(plan);
        send_sample('{16'sd1, -16'sd1, 16'sd3});
        send_sample('{SAMPLE_MIN, SAMPLE_MAX, -16'sd3});
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            foreach (plan[i]) plan[i] = pick_coef(mix_plan[p], i);
            load_coefs(plan);
            no_idle = (p == 0);
            s = '0;
            repeat (PHASE_ITEMS) begin
                s.x = pick_sample(s.x);
                s.y = pick_sample(s.y);
                s.z = pick_sample(s.z);
                send_sample(s);
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
sv/tolpf_pkg.sv
sv/third_order_lowpass_three_axis_core.sv
sv/tolpf_checker.sv
tb/sv/tb_top.sv
